// ===== hdl/pwir_pkg.sv =====
// Shared types and constants of the pulse-width infrared command transmitter.
`default_nettype none
package pwir_pkg;

    // Frame layout
    localparam int FRAME_BITS = 8;
    localparam int BIT_IDX_W  = $clog2(FRAME_BITS);
    localparam int CMD_W      = 3;
    localparam int DAT_W      = 5;
    localparam int TICK_W     = 16;
    localparam int REP_W      = 3;

    // Configuration register indexes
    localparam logic [2:0] REG_SYNC_HIGH = 3'd0;
    localparam logic [2:0] REG_LOW       = 3'd1;
    localparam logic [2:0] REG_ZERO_HIGH = 3'd2;
    localparam logic [2:0] REG_ONE_HIGH  = 3'd3;
    localparam logic [2:0] REG_GAP       = 3'd4;
    localparam logic [2:0] REG_REPEAT    = 3'd5;

    // Register reset values
    localparam logic [TICK_W-1:0] SYNC_HIGH_RST = 16'd2400;
    localparam logic [TICK_W-1:0] LOW_RST       = 16'd600;
    localparam logic [TICK_W-1:0] ZERO_HIGH_RST = 16'd600;
    localparam logic [TICK_W-1:0] ONE_HIGH_RST  = 16'd1200;
    localparam logic [TICK_W-1:0] GAP_RST       = 16'd45000;
    localparam logic [REP_W-1:0]  REPEAT_RST    = 3'd3;

    // Timing configuration as seen by the core
    typedef struct packed {
        logic [TICK_W-1:0] sync_high_ticks;
        logic [TICK_W-1:0] low_ticks;
        logic [TICK_W-1:0] zero_high_ticks;
        logic [TICK_W-1:0] one_high_ticks;
        logic [TICK_W-1:0] gap_ticks;
        logic [REP_W-1:0]  repeat_count;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic start_ignored;
    } result_t;

endpackage
`default_nettype wire

// ===== hdl/pwir_cfg.sv =====
// Configuration register bank of the infrared transmitter.
`default_nettype none
module pwir_cfg
    import pwir_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic [2:0]  wr_index,
    input  wire logic [15:0] wr_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write onto one register; other indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_SYNC_HIGH: cfg_next.sync_high_ticks = wr_data;
                REG_LOW:       cfg_next.low_ticks       = wr_data;
                REG_ZERO_HIGH: cfg_next.zero_high_ticks = wr_data;
                REG_ONE_HIGH:  cfg_next.one_high_ticks  = wr_data;
                REG_GAP:       cfg_next.gap_ticks       = wr_data;
                REG_REPEAT:    cfg_next.repeat_count    = wr_data[REP_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_high_ticks <= SYNC_HIGH_RST;
            cfg_reg.low_ticks       <= LOW_RST;
            cfg_reg.zero_high_ticks <= ZERO_HIGH_RST;
            cfg_reg.one_high_ticks  <= ONE_HIGH_RST;
            cfg_reg.gap_ticks       <= GAP_RST;
            cfg_reg.repeat_count    <= REPEAT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== hdl/pwir_core.sv =====
// Phase sequencer and tick timer of the infrared transmitter.
`default_nettype none
module pwir_core
    import pwir_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic             func,
    input  wire logic [CMD_W-1:0] command,
    input  wire logic [DAT_W-1:0] data_bits,
    input  wire cfg_t             cfg,
    output result_t               result
);

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_SYNC_HIGH = 3'd1;
    localparam logic [2:0] PH_SYNC_LOW  = 3'd2;
    localparam logic [2:0] PH_BIT_HIGH  = 3'd3;
    localparam logic [2:0] PH_BIT_LOW   = 3'd4;
    localparam logic [2:0] PH_GAP       = 3'd5;

    localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(FRAME_BITS - 1);

    logic [2:0]            phase_reg,  phase_next;
    logic [FRAME_BITS-1:0] frame_reg,  frame_next;
    logic [FRAME_BITS-1:0] shift_reg,  shift_next;
    logic [BIT_IDX_W-1:0]  bit_reg,    bit_next;
    logic [REP_W-1:0]      rep_reg,    rep_next;
    logic [TICK_W-1:0]     timer_reg,  timer_next;

    logic              busy;
    logic              level;
    logic [TICK_W-1:0] dur_raw;
    logic [TICK_W-1:0] dur;
    logic [REP_W-1:0]  reps;
    logic              phase_done;

    assign busy  = (phase_reg != PH_IDLE);
    assign level = (phase_reg == PH_SYNC_HIGH) || (phase_reg == PH_BIT_HIGH);

    // Pick the length of the current phase; a zero length counts as one tick
    always_comb
    begin
        case (phase_reg)
            PH_SYNC_HIGH: dur_raw = cfg.sync_high_ticks;
            PH_SYNC_LOW:  dur_raw = cfg.low_ticks;
            PH_BIT_HIGH:  dur_raw = shift_reg[FRAME_BITS-1] ? cfg.one_high_ticks
                                                           : cfg.zero_high_ticks;
            PH_BIT_LOW:   dur_raw = cfg.low_ticks;
            PH_GAP:       dur_raw = cfg.gap_ticks;
            default:      dur_raw = TICK_W'(1);
        endcase
    end

    assign dur  = (dur_raw == '0) ? TICK_W'(1) : dur_raw;
    assign reps = (cfg.repeat_count == '0) ? REP_W'(1) : cfg.repeat_count;
    assign phase_done = ({1'b0, timer_reg} + (TICK_W+1)'(1)) >= {1'b0, dur};

    // Advance the sequencer for one item and form its result
    always_comb
    begin
        phase_next = phase_reg;
        frame_next = frame_reg;
        shift_next = shift_reg;
        bit_next   = bit_reg;
        rep_next   = rep_reg;
        timer_next = timer_reg;
        result.line_level    = level;
        result.busy_res      = busy;
        result.start_ignored = 1'b0;

        if (func)
        begin
            // Start: load the frame when idle, drop it otherwise
            if (busy)
            begin
                result.start_ignored = 1'b1;
            end
            else
            begin
                frame_next = {command, data_bits};
                shift_next = {command, data_bits};
                bit_next   = '0;
                rep_next   = '0;
                timer_next = '0;
                phase_next = PH_SYNC_HIGH;
                result.line_level = 1'b1;
                result.busy_res   = 1'b1;
            end
        end
        else if (busy)
        begin
            if (!phase_done)
            begin
                timer_next = timer_reg + TICK_W'(1);
            end
            else
            begin
                timer_next = '0;
                case (phase_reg)
                    PH_SYNC_HIGH: phase_next = PH_SYNC_LOW;
                    PH_SYNC_LOW:  phase_next = PH_BIT_HIGH;
                    PH_BIT_HIGH:  phase_next = PH_BIT_LOW;
                    PH_BIT_LOW:
                    begin
                        shift_next = {shift_reg[FRAME_BITS-2:0], 1'b0};
                        if (bit_reg == LAST_BIT)
                        begin
                            bit_next   = '0;
                            phase_next = PH_GAP;
                        end
                        else
                        begin
                            bit_next   = bit_reg + BIT_IDX_W'(1);
                            phase_next = PH_BIT_HIGH;
                        end
                    end
                    PH_GAP:
                    begin
                        if (({1'b0, rep_reg} + (REP_W+1)'(1)) >= {1'b0, reps})
                        begin
                            rep_next   = '0;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            // Reload the byte so every repetition is the same
                            rep_next   = rep_reg + REP_W'(1);
                            shift_next = frame_reg;
                            bit_next   = '0;
                            phase_next = PH_BIT_HIGH;
                        end
                    end
                    default:      phase_next = PH_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            frame_reg <= '0;
            shift_reg <= '0;
            bit_reg   <= '0;
            rep_reg   <= '0;
            timer_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            frame_reg <= frame_next;
            shift_reg <= shift_next;
            bit_reg   <= bit_next;
            rep_reg   <= rep_next;
            timer_reg <= timer_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/pulse_width_ir_command_transmitter.sv =====
// Top level of the pulse-width infrared command transmitter.
// Each input item is either a time tick (tuser = 0) or a start request (tuser = 1)
// carrying a 3-bit command and 5-bit payload, sent MSB first as one byte after a
// sync pulse, repeated repeat_count times with a low gap after each pass. Every
// item yields exactly one result item: the line level for that tick, a busy flag
// and a flag for a start dropped because a transmission was running. An item
// is held in the input register while the sequencer works on it, and its result
// is then registered in the output register; one item is taken every cycle while
// the output side keeps up. A stalled output holds the item in the input register
// and drops tready. Configuration writes are taken in any cycle and should only
// be made while no item is in flight.
`default_nettype none
module pulse_width_ir_command_transmitter
    import pwir_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input item stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [2:0] command, [7:3] data_bits
    input  wire logic        s_axis_tuser,   // [0] func
    // Result item stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [0] line_level, [1] busy_res,
                                             // [2] start_ignored, [7:3] zero
    // Configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    cfg_t    cfg;
    result_t result;

    logic             in_vld_reg;
    logic             in_func_reg;
    logic [CMD_W-1:0] in_cmd_reg;
    logic [DAT_W-1:0] in_dat_reg;
    logic             out_vld_reg;
    result_t          out_res_reg;
    logic             advance;
    logic             accept;

    // Move the held item through the sequencer when the output slot frees
    assign advance       = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    pwir_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    pwir_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .func      (in_func_reg),
        .command   (in_cmd_reg),
        .data_bits (in_dat_reg),
        .cfg       (cfg),
        .result    (result)
    );

    // Hold the accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_func_reg <= s_axis_tuser;
            in_cmd_reg  <= s_axis_tdata[CMD_W-1:0];
            in_dat_reg  <= s_axis_tdata[CMD_W+DAT_W-1:CMD_W];
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= result;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {5'b0, out_res_reg.start_ignored, out_res_reg.busy_res,
                            out_res_reg.line_level};

endmodule
`default_nettype wire

// ===== dv/pulse_width_ir_command_transmitter_test.sv =====
// Self-checking testbench for the pulse-width infrared command transmitter.
`default_nettype none
module pulse_width_ir_command_transmitter_test;
    import pwir_pkg::*;

    // Run control
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int RANDOM_ITEMS   = 150;
    localparam int HOLD_TICKS     = 40;
    localparam int PRINT_LIMIT    = 50;

    // Register indexes beyond the implemented set
    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    // Item kinds carried on tuser
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    typedef enum logic [2:0] {
        TX_IDLE,
        TX_SYNC_HIGH,
        TX_SYNC_LOW,
        TX_BIT_HIGH,
        TX_BIT_LOW,
        TX_GAP
    } tx_phase_e;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;   // [2:0] command, [7:3] data_bits
    logic        s_axis_tuser  = 1'b0;   // [0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // [0] line_level, [1] busy_res,
                                         // [2] start_ignored, [7:3] zero
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index     = 3'd0;
    logic [15:0] cfg_data      = 16'd0;

    // Transmitter state as predicted
    tx_phase_e             tx_phase = TX_IDLE;
    logic [7:0]            tx_frame = 8'd0;
    logic [7:0]            tx_shift = 8'd0;
    logic [BIT_IDX_W-1:0]  tx_bit   = '0;
    logic [REP_W-1:0]      tx_rep   = '0;
    logic [TICK_W-1:0]     tx_timer = '0;
    cfg_t                  tx_cfg   = '{SYNC_HIGH_RST, LOW_RST, ZERO_HIGH_RST,
                                        ONE_HIGH_RST, GAP_RST, REPEAT_RST};

    result_t pending_results[$];
    bit      pacing       = 1'b1;
    int      mismatches   = 0;
    int      items_sent   = 0;
    int      results_seen = 0;
    int      quiet_cycles = 0;

    pulse_width_ir_command_transmitter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // Work out the result of one item and advance the predicted state
    function automatic result_t predict_line(input logic func, input logic [CMD_W-1:0] cmd,
                                             input logic [DAT_W-1:0] dat);
        result_t            r;
        logic [TICK_W-1:0]  len;
        logic [REP_W-1:0]   reps;
        r = '0;
        if (func == FUNC_START) begin
            if (tx_phase != TX_IDLE) begin
                r.start_ignored = 1'b1;
            end
            else begin
                tx_frame = {cmd, dat};
                tx_shift = {cmd, dat};
                tx_bit   = '0;
                tx_rep   = '0;
                tx_timer = '0;
                tx_phase = TX_SYNC_HIGH;
            end
            r.line_level = (tx_phase == TX_SYNC_HIGH) || (tx_phase == TX_BIT_HIGH);
            r.busy_res   = (tx_phase != TX_IDLE);
            return r;
        end
        r.line_level = (tx_phase == TX_SYNC_HIGH) || (tx_phase == TX_BIT_HIGH);
        r.busy_res   = (tx_phase != TX_IDLE);
        if (tx_phase == TX_IDLE)
            return r;
        // Length of the current phase; a zero setting counts as one tick
        case (tx_phase)
            TX_SYNC_HIGH: len = tx_cfg.sync_high_ticks;
            TX_SYNC_LOW:  len = tx_cfg.low_ticks;
            TX_BIT_HIGH:  len = tx_shift[FRAME_BITS-1] ? tx_cfg.one_high_ticks
                                                       : tx_cfg.zero_high_ticks;
            TX_BIT_LOW:   len = tx_cfg.low_ticks;
            TX_GAP:       len = tx_cfg.gap_ticks;
            default:      len = 16'd1;
        endcase
        if (len == '0)
            len = 16'd1;
        if ({1'b0, tx_timer} + 17'd1 < {1'b0, len}) begin
            tx_timer = tx_timer + TICK_W'(1);
            return r;
        end
        // Phase over: move on
        tx_timer = '0;
        case (tx_phase)
            TX_SYNC_HIGH: tx_phase = TX_SYNC_LOW;
            TX_SYNC_LOW:  tx_phase = TX_BIT_HIGH;
            TX_BIT_HIGH:  tx_phase = TX_BIT_LOW;
            TX_BIT_LOW:
            begin
                tx_shift = tx_shift << 1;
                if (tx_bit == BIT_IDX_W'(FRAME_BITS - 1)) begin
                    tx_bit   = '0;
                    tx_phase = TX_GAP;
                end
                else begin
                    tx_bit   = tx_bit + BIT_IDX_W'(1);
                    tx_phase = TX_BIT_HIGH;
                end
            end
            TX_GAP:
            begin
                reps = (tx_cfg.repeat_count == '0) ? REP_W'(1) : tx_cfg.repeat_count;
                if ({1'b0, tx_rep} + 4'd1 >= {1'b0, reps}) begin
                    tx_rep   = '0;
                    tx_phase = TX_IDLE;
                end
                else begin
                    tx_rep   = tx_rep + REP_W'(1);
                    tx_shift = tx_frame;
                    tx_bit   = '0;
                    tx_phase = TX_BIT_HIGH;
                end
            end
            default: tx_phase = TX_IDLE;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t: result %0d, %s: got %0d, expected %0d",
                     $time, results_seen, what, got, want);
    endtask

    // Offer one item after a random gap and log its expected result
    task automatic send_item(input logic func, input logic [CMD_W-1:0] cmd,
                             input logic [DAT_W-1:0] dat);
        int gap;
        gap = pacing ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {dat, cmd};
        s_axis_tuser  <= func;
        do @(posedge clk); while (!s_axis_tready);
        pending_results.push_back(predict_line(func, cmd, dat));
        items_sent++;
    endtask

    // Send a fixed number of ticks
    task automatic send_ticks(input int count);
        repeat (count)
            send_item(FUNC_TICK, CMD_W'($urandom), DAT_W'($urandom));
    endtask

    // Tick until the transmission ends, dropping in a busy start now and then
    task automatic run_to_idle(input int start_odds);
        while (tx_phase != TX_IDLE) begin
            if (start_odds > 0 && $urandom_range(1, start_odds) == 1)
                send_item(FUNC_START, CMD_W'($urandom), DAT_W'($urandom));
            else
                send_item(FUNC_TICK, CMD_W'($urandom), DAT_W'($urandom));
        end
    endtask

    // Hold the input until every expected result is in, then let the pipe empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one register; valid stays high for a following write
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_SYNC_HIGH: tx_cfg.sync_high_ticks = val;
            REG_LOW:       tx_cfg.low_ticks       = val;
            REG_ZERO_HIGH: tx_cfg.zero_high_ticks = val;
            REG_ONE_HIGH:  tx_cfg.one_high_ticks  = val;
            REG_GAP:       tx_cfg.gap_ticks       = val;
            REG_REPEAT:    tx_cfg.repeat_count    = val[REP_W-1:0];
            default:       ;
        endcase
    endtask

    task automatic configure(input logic [15:0] sync_high, input logic [15:0] low,
                             input logic [15:0] zero_high, input logic [15:0] one_high,
                             input logic [15:0] gap, input logic [15:0] reps);
        settle();
        write_reg(REG_SYNC_HIGH, sync_high);
        write_reg(REG_LOW, low);
        write_reg(REG_ZERO_HIGH, zero_high);
        write_reg(REG_ONE_HIGH, one_high);
        write_reg(REG_GAP, gap);
        write_reg(REG_REPEAT, reps);
        cfg_valid <= 1'b0;
    endtask

    // Idle ticks keep the line low, with the field extremes on the input
    task automatic test_idle_ticks();
        pacing = 1'b1;
        send_item(FUNC_TICK, 3'd0, 5'd0);
        send_item(FUNC_TICK, 3'd7, 5'd31);
        send_item(FUNC_TICK, 3'd5, 5'd10);
    endtask

    // Sync pulse with the timing left at reset and a start while busy,
    // then shorter timing written mid-frame to finish it
    task automatic test_reset_timing();
        pacing = 1'b0;
        send_item(FUNC_START, 3'd5, 5'd10);
        send_item(FUNC_START, 3'd2, 5'd21);
        send_ticks(HOLD_TICKS);
        pacing = 1'b1;
        configure(16'd1, 16'd1, 16'd1, 16'd2, 16'd1, 16'd2);
        run_to_idle(8);
        settle();
    endtask

    // Shortest settings, all-zero and all-one bytes
    task automatic test_min_durations();
        pacing = 1'b1;
        configure(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        send_item(FUNC_START, 3'd0, 5'd0);
        run_to_idle(0);
        send_item(FUNC_START, 3'd7, 5'd31);
        run_to_idle(6);
    endtask

    // Zero durations and zero repeats count as one; repeat takes its low bits
    task automatic test_zero_settings();
        configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_item(FUNC_START, 3'd3, 5'd17);
        run_to_idle(8);
        settle();
        write_reg(REG_REPEAT, 16'hFFFA);
        cfg_valid <= 1'b0;
        send_item(FUNC_START, 3'd6, 5'd9);
        run_to_idle(8);
    endtask

    // Writes to unused indexes must leave the timing alone
    task automatic test_bad_index();
        configure(16'd3, 16'd2, 16'd1, 16'd3, 16'd2, 16'd2);
        write_reg(REG_SPARE_6, 16'($urandom));
        write_reg(REG_SPARE_7, 16'hFFFF);
        cfg_valid <= 1'b0;
        send_item(FUNC_START, 3'd4, 5'd22);
        run_to_idle(8);
    endtask

    task automatic test_max_repeat();
        configure(16'd2, 16'd1, 16'd1, 16'd2, 16'd3, 16'd7);
        send_item(FUNC_START, 3'($urandom), 5'($urandom));
        run_to_idle(10);
    endtask

    // Longest settings hold the sync pulse; shorter ones written mid-frame end it
    task automatic test_long_phases();
        configure(16'hFFFF, 16'd1, 16'd1, 16'hFFFF, 16'hFFFF, 16'd1);
        pacing = 1'b0;
        send_item(FUNC_START, 3'd0, 5'd1);
        send_ticks(HOLD_TICKS);
        pacing = 1'b1;
        configure(16'd2, 16'd1, 16'd1, 16'd3, 16'd2, 16'd1);
        run_to_idle(8);
    endtask

    // Short random frames under random settings, with idle noise and busy starts
    task automatic test_random_traffic();
        int first;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS) begin
            configure(16'($urandom_range(0, 3)), 16'($urandom_range(0, 2)),
                      16'($urandom_range(0, 2)), 16'($urandom_range(0, 3)),
                      16'($urandom_range(0, 3)),
                      ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3)));
            pacing = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(0, 3))
                send_item(FUNC_TICK, CMD_W'($urandom), DAT_W'($urandom));
            send_item(FUNC_START, CMD_W'($urandom), DAT_W'($urandom));
            run_to_idle(10);
        end
        pacing = 1'b1;
    endtask

    // Accept results after a random stall and check them against the oldest expectation
    initial
    begin
        int      stall;
        result_t want;
        forever begin
            stall = pacing ? $urandom_range(0, 4) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (m_axis_tvalid !== 1'b1);
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected", m_axis_tdata, 0);
            end
            else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[0] !== want.line_level)
                    report_mismatch("line_level", m_axis_tdata[0], want.line_level);
                if (m_axis_tdata[1] !== want.busy_res)
                    report_mismatch("busy_res", m_axis_tdata[1], want.busy_res);
                if (m_axis_tdata[2] !== want.start_ignored)
                    report_mismatch("start_ignored", m_axis_tdata[2], want.start_ignored);
                if (m_axis_tdata[7:3] !== 5'd0)
                    report_mismatch("padding", m_axis_tdata[7:3], 0);
            end
        end
    end

    // Count cycles in which no channel moves anything
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_ticks();
        test_reset_timing();
        test_min_durations();
        test_zero_settings();
        test_bad_index();
        test_max_repeat();
        test_long_phases();
        test_random_traffic();
        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
hdl/pwir_pkg.sv
hdl/pwir_cfg.sv
hdl/pwir_core.sv
hdl/pulse_width_ir_command_transmitter.sv
dv/pulse_width_ir_command_transmitter_test.sv
